// ----- hw/rtl/mjpd_pkg.sv -----
package mjpd_pkg;

	localparam int MAX_JOINTS_DEF = 32;

	localparam int JNT_W  = 5;
	localparam int RATE_W = 16;
	localparam int ANG_W  = 32;
	localparam int VEL_W  = 48;
	localparam int DIFF_W = VEL_W + 1;
	localparam int GAIN_W = 25;
	localparam int PROD_W = DIFF_W + GAIN_W;
	localparam int ACC_W  = 60;
	localparam int TRQ_W  = 20;
	localparam int HIST_W = 2 * ANG_W + 2 * VEL_W;

	localparam logic [RATE_W-1:0] RATE_RST = 16'd1000;

	localparam logic signed [VEL_W-1:0] ONE_RAD_S = 48'sd1048576;

	localparam int TORQUE_DIV  = 20480;
	localparam int DIV_SHIFT   = 12;
	localparam int RECIP_SHIFT = 26;
	localparam int QUOT_W      = 24;

	localparam logic [GAIN_W-1:0] RECIP5 = 25'd13421773;
	localparam logic [QUOT_W-1:0] Y_BIAS = 24'd10485760;
	localparam logic [QUOT_W-1:0] Q_BIAS = 24'd2097152;

	localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}};

	typedef enum logic [1:0] {
		RULE_POS,
		RULE_J25,
		RULE_VEL
	} rule_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] kd;
		logic [TRQ_W-1:0]         lim;
		rule_t                    rule;
	} jclass_t;

	// Gains are stored negated and scaled by five, the limit in torque LSBs.
	function automatic jclass_t joint_class(input logic [JNT_W-1:0] j);
		jclass_t c;
		c.rule = RULE_POS;
		if (j <= 5'd2) begin
			c.kp  = -25'sd300000;
			c.kd  = -25'sd1200;
			c.lim = 20'd307200;
		end else if (j <= 5'd20) begin
			c.kp  = -25'sd100000;
			c.kd  = -25'sd1600;
			c.lim = 20'd153600;
		end else if (j <= 5'd25) begin
			c.kp  = -25'sd2000;
			c.kd  = -25'sd50;
			c.lim = 20'd35840;
		end else if (j <= 5'd29) begin
			c.kp  = -25'sd200000;
			c.kd  = -25'sd1200;
			c.lim = 20'd102400;
		end else begin
			c.kp   = -25'sd200;
			c.kd   = -25'sd50;
			c.lim  = 20'd2560;
			c.rule = RULE_VEL;
		end
		if (j == 5'd25) begin
			c.kp   = -25'sd500;
			c.kd   = -25'sd1;
			c.rule = RULE_J25;
		end
		return c;
	endfunction

	function automatic logic signed [VEL_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
		logic signed [VEL_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[VEL_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[VEL_W-1:0];
		end else begin
			r = v[VEL_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp_hi(input logic [TRQ_W-1:0] lim);
		logic [ACC_W-1:0] l;
		l = ACC_W'(lim);
		return $signed((l + ACC_W'(1)) * ACC_W'(TORQUE_DIV));
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp_lo(input logic [TRQ_W-1:0] lim);
		logic [ACC_W-1:0] l;
		l = ACC_W'(lim);
		return $signed(-(l * ACC_W'(TORQUE_DIV)));
	endfunction

endpackage

// ----- hw/rtl/mjpd_if.sv -----
interface mjpd_in_if import mjpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [JNT_W-1:0]        joint;
	logic signed [ANG_W-1:0] angle;
	logic signed [ANG_W-1:0] angle_ref;

	modport source (output valid, action, joint, angle, angle_ref, input ready);
	modport sink (input valid, action, joint, angle, angle_ref, output ready);
endinterface

interface mjpd_out_if import mjpd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [JNT_W-1:0]        joint_out;
	logic signed [TRQ_W-1:0] torque;
	logic                    clamped;

	modport source (output valid, joint_out, torque, clamped, input ready);
	modport sink (input valid, joint_out, torque, clamped, output ready);
endinterface

// ----- hw/rtl/mjpd_ram.sv -----
module mjpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/mjpd_mul.sv -----
module mjpd_mul import mjpd_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DIFF_W-1:0] a,
	input  logic signed [GAIN_W-1:0] b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

// ----- hw/rtl/multi_joint_pd_torque_controller.sv -----
// Per-joint PD torque controller. A seed transaction loads a joint's history in the cycle it
// is accepted and produces no result. A step transaction computes velocity and acceleration
// by backward differences scaled by rate_hz, applies the joint class gains, divides the sum
// down to 2^-8 Nm with rounding toward minus infinity, clamps it to the class limit and
// returns one result. All multiplications of a step go one after another through a single
// registered 49 by 25 bit multiplier, seven passes through the OPND, MULT and WB states, so a
// step keeps the input side busy from acceptance until its result can enter the output register;
// a finished result waits there while the next transaction is accepted. History lives in a RAM
// with a registered read; rate_hz may only be written while no step is in progress.
module multi_joint_pd_torque_controller import mjpd_pkg::*; #(
	parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RATE_W-1:0] cfg_wdata,
	mjpd_in_if.sink           item,
	mjpd_out_if.source        result
);

	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_OPND = 5'b00100,
		ST_MULT = 5'b01000,
		ST_WB   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		OP_DQ,
		OP_DQR,
		OP_DDQ,
		OP_DDQR,
		OP_T1,
		OP_T2,
		OP_DIV
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [RATE_W-1:0] rate_q;

	logic [JNT_W-1:0]        joint_q;
	logic signed [ANG_W-1:0] q_q;
	logic signed [ANG_W-1:0] qr_q;
	logic signed [VEL_W-1:0] dq_q;
	logic signed [VEL_W-1:0] dqr_q;
	logic signed [VEL_W-1:0] ddq_q;
	logic signed [VEL_W-1:0] ddqr_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    hi_q;
	logic                    lo_q;
	logic signed [DIFF_W-1:0] a_q;
	logic signed [GAIN_W-1:0] b_q;

	logic                    out_valid_q;
	logic [JNT_W-1:0]        out_joint_q;
	logic signed [TRQ_W-1:0] out_torque_q;
	logic                    out_clamped_q;

	logic                     accept;
	logic                     jvalid;
	logic                     seed_wr;
	logic                     step_wr;
	logic                     final_go;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [HIST_W-1:0]        ram_wdata;
	logic [HIST_W-1:0]        ram_rdata;
	logic signed [PROD_W-1:0] prod;
	jclass_t                  cls;
	jclass_t                  cls_out;

	logic signed [ANG_W-1:0]  la;
	logic signed [ANG_W-1:0]  lr;
	logic signed [VEL_W-1:0]  lv;
	logic signed [VEL_W-1:0]  lrv;

	logic signed [DIFF_W-1:0] a_d;
	logic signed [GAIN_W-1:0] b_d;
	logic signed [GAIN_W-1:0] rate_op;
	logic [ACC_W-1:0]         ysum;
	logic [QUOT_W-1:0]        quot;
	logic [QUOT_W-1:0]        tq;
	logic signed [TRQ_W-1:0]  torque_d;

	assign accept  = item.valid && item.ready;
	assign jvalid  = {4'd0, item.joint} < 9'(MAX_JOINTS);
	assign seed_wr = accept && !item.action && jvalid;
	assign step_wr = (state_q == ST_WB) && (op_q == OP_DDQR);
	assign final_go = (state_q == ST_WB) && (op_q == OP_DIV) && (!out_valid_q || result.ready);

	assign item.ready = (state_q == ST_IDLE);

	assign la  = ram_rdata[HIST_W-1 -: ANG_W];
	assign lr  = ram_rdata[HIST_W-ANG_W-1 -: ANG_W];
	assign lv  = ram_rdata[2*VEL_W-1 -: VEL_W];
	assign lrv = ram_rdata[VEL_W-1:0];

	assign ram_we    = seed_wr || step_wr;
	assign ram_waddr = seed_wr ? AW'(item.joint) : AW'(joint_q);
	assign ram_wdata = seed_wr ? {item.angle, item.angle, {(2*VEL_W){1'b0}}}
	                           : {q_q, qr_q, dq_q, dqr_q};

	mjpd_ram #(
		.WIDTH(HIST_W),
		.DEPTH(MAX_JOINTS)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(item.joint)),
		.rdata(ram_rdata)
	);

	mjpd_mul u_mul (
		.clk (clk),
		.en  (state_q == ST_MULT),
		.a   (a_q),
		.b   (b_q),
		.prod(prod)
	);

	always_comb begin
		cls     = joint_class(joint_q);
		cls_out = joint_class(out_joint_q);
		rate_op = $signed({{(GAIN_W-RATE_W){1'b0}}, rate_q});
		ysum    = ACC_W'(acc_q >>> DIV_SHIFT) + ACC_W'(Y_BIAS);
		a_d     = '0;
		b_d     = rate_op;
		unique case (op_q)
			OP_DQ: begin
				a_d = DIFF_W'(q_q) - DIFF_W'(la);
			end
			OP_DQR: begin
				a_d = DIFF_W'(qr_q) - DIFF_W'(lr);
			end
			OP_DDQ: begin
				a_d = DIFF_W'(dq_q) - DIFF_W'(lv);
			end
			OP_DDQR: begin
				a_d = DIFF_W'(dqr_q) - DIFF_W'(lrv);
			end
			OP_T1: begin
				b_d = cls.kp;
				unique case (cls.rule)
					RULE_J25: a_d = DIFF_W'(sat48(PROD_W'(DIFF_W'(dq_q) - DIFF_W'(ONE_RAD_S))));
					RULE_VEL: a_d = DIFF_W'(sat48(PROD_W'(DIFF_W'(dq_q) - DIFF_W'(qr_q))));
					default:  a_d = DIFF_W'(q_q) - DIFF_W'(qr_q);
				endcase
			end
			OP_T2: begin
				b_d = cls.kd;
				unique case (cls.rule)
					RULE_J25: a_d = DIFF_W'(ddq_q);
					RULE_VEL: a_d = DIFF_W'(sat48(PROD_W'(DIFF_W'(ddq_q) - DIFF_W'(ddqr_q))));
					default:  a_d = DIFF_W'(sat48(PROD_W'(DIFF_W'(dq_q) - DIFF_W'(dqr_q))));
				endcase
			end
			OP_DIV: begin
				a_d = $signed({{(DIFF_W-QUOT_W){1'b0}}, ysum[QUOT_W-1:0]});
				b_d = $signed(RECIP5);
			end
			default: begin
				a_d = '0;
			end
		endcase
	end

	always_comb begin
		quot = prod[RECIP_SHIFT +: QUOT_W];
		tq   = quot - Q_BIAS;
		if (hi_q) begin
			torque_d = $signed(cls.lim);
		end else if (lo_q) begin
			torque_d = -$signed(cls.lim);
		end else begin
			torque_d = $signed(tq[TRQ_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DQ;
			rate_q      <= RATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (final_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.action && jvalid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					op_q    <= OP_DQ;
					state_q <= ST_OPND;
				end
				ST_OPND: begin
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (op_q != OP_DIV) begin
						op_q    <= op_t'(op_q + 3'd1);
						state_q <= ST_OPND;
					end else if (final_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			joint_q <= item.joint;
			q_q     <= item.angle;
			qr_q    <= item.angle_ref;
		end
		if (state_q == ST_OPND) begin
			a_q <= a_d;
			b_q <= b_d;
			if (op_q == OP_DIV) begin
				hi_q <= acc_q >= clamp_hi(cls.lim);
				lo_q <= acc_q < clamp_lo(cls.lim);
			end
		end
		if (state_q == ST_WB) begin
			unique case (op_q)
				OP_DQ:   dq_q   <= sat48(prod);
				OP_DQR:  dqr_q  <= sat48(prod);
				OP_DDQ:  ddq_q  <= sat48(prod);
				OP_DDQR: ddqr_q <= sat48(prod);
				OP_T1:   acc_q  <= prod[ACC_W-1:0];
				OP_T2:   acc_q  <= acc_q + prod[ACC_W-1:0];
				default: begin
				end
			endcase
		end
		if (final_go) begin
			out_joint_q   <= joint_q;
			out_torque_q  <= torque_d;
			out_clamped_q <= hi_q || lo_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.joint_out = out_joint_q;
	assign result.torque    = out_torque_q;
	assign result.clamped   = out_clamped_q;

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WB && op_q == OP_DIV))
		else $error("result appeared without a completed step");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.clamped) |->
		(result.torque == $signed(cls_out.lim) || result.torque == -$signed(cls_out.lim)))
		else $error("clamped torque is not at the class limit");

	a_torque_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
		(result.torque <= $signed(cls_out.lim) && result.torque >= -$signed(cls_out.lim)))
		else $error("torque outside the class limit");

	a_no_write_while_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_IDLE) |-> (state_q == ST_WB && op_q == OP_DDQR))
		else $error("history written outside the step write-back");

endmodule

// ----- test/multi_joint_pd_torque_controller_tb.sv -----
module multi_joint_pd_torque_controller_tb import mjpd_pkg::*; ();

	localparam logic ACT_SEED = 1'b0;
	localparam logic ACT_STEP = 1'b1;
	localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
	localparam longint MIN48 = -MAX48 - 1;
	localparam int NUM_JOINTS = 32;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [JNT_W-1:0]        joint;
		logic signed [TRQ_W-1:0] torque;
		logic                    clamped;
	} torque_cmd_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_wdata;

	mjpd_in_if  item_if();
	mjpd_out_if result_if();

	multi_joint_pd_torque_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_if),
		.result   (result_if)
	);

	logic [RATE_W-1:0]       model_rate;
	logic signed [ANG_W-1:0] hist_angle   [NUM_JOINTS];
	logic signed [ANG_W-1:0] hist_ref     [NUM_JOINTS];
	logic signed [VEL_W-1:0] hist_vel     [NUM_JOINTS];
	logic signed [VEL_W-1:0] hist_ref_vel [NUM_JOINTS];
	bit                      seeded       [NUM_JOINTS];

	torque_cmd_t torque_q[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  seeds_sent = 0;
	int  results_checked = 0;
	int  rate_writes = 0;
	bit  full_rate = 0;
	int  stall_request = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic longint sat48(input longint v);
		if (v > MAX48) begin
			return MAX48;
		end
		if (v < MIN48) begin
			return MIN48;
		end
		return v;
	endfunction

	function automatic longint rate_scale(input longint a, input logic [RATE_W-1:0] r);
		longint unsigned m;
		longint          p;
		if (r == 0) begin
			return 0;
		end
		m = (a < 0) ? -a : a;
		if (m > longint'(MAX48) / r) begin
			return (a < 0) ? MIN48 : MAX48;
		end
		p = m * r;
		return (a < 0) ? -p : p;
	endfunction

	function automatic void class_gains(input logic [JNT_W-1:0] j, output longint p,
		output longint d, output longint lim, output rule_t rule);
		rule = RULE_POS;
		if (j <= 2) begin
			p = 60000; d = 240; lim = 1200;
		end else if (j <= 20) begin
			p = 20000; d = 320; lim = 600;
		end else if (j <= 25) begin
			p = 400; d = 10; lim = 140;
		end else if (j <= 29) begin
			p = 40000; d = 240; lim = 400;
		end else begin
			p = 40; d = 10; lim = 10;
			rule = RULE_VEL;
		end
		if (j == 25) begin
			rule = RULE_J25;
		end
	endfunction

	// Updates the joint history for one accepted transaction and returns 1 with the
	// torque command when the transaction is a step.
	function automatic bit advance_joint(input logic act, input logic [JNT_W-1:0] j,
		input logic signed [ANG_W-1:0] q_in, input logic signed [ANG_W-1:0] qr_in,
		output torque_cmd_t cmd);
		longint q, qr, dq, dqr, ddq, ddqr, s, t, p, d, lim;
		rule_t  rule;
		q = q_in;
		qr = qr_in;
		cmd = '0;
		if (act == ACT_SEED) begin
			hist_angle[j] = q_in;
			hist_ref[j] = q_in;
			hist_vel[j] = '0;
			hist_ref_vel[j] = '0;
			seeded[j] = 1'b1;
			return 1'b0;
		end
		dq = rate_scale(q - longint'(hist_angle[j]), model_rate);
		dqr = rate_scale(qr - longint'(hist_ref[j]), model_rate);
		ddq = rate_scale(dq - longint'(hist_vel[j]), model_rate);
		ddqr = rate_scale(dqr - longint'(hist_ref_vel[j]), model_rate);
		hist_angle[j] = q_in;
		hist_ref[j] = qr_in;
		hist_vel[j] = dq[VEL_W-1:0];
		hist_ref_vel[j] = dqr[VEL_W-1:0];
		class_gains(j, p, d, lim, rule);
		case (rule)
			RULE_J25: begin
				s = -500 * sat48(dq - longint'(ONE_RAD_S)) - ddq;
			end
			RULE_VEL: begin
				s = -5 * p * sat48(dq - qr) - 5 * d * sat48(ddq - ddqr);
			end
			default: begin
				s = -5 * p * (q - qr) - 5 * d * sat48(dq - dqr);
			end
		endcase
		t = s / TORQUE_DIV;
		if (s < 0 && (s % TORQUE_DIV) != 0) begin
			t = t - 1;
		end
		lim = lim * 256;
		cmd.clamped = 1'b0;
		if (t > lim) begin
			t = lim;
			cmd.clamped = 1'b1;
		end else if (t < -lim) begin
			t = -lim;
			cmd.clamped = 1'b1;
		end
		cmd.joint = j;
		cmd.torque = t[TRQ_W-1:0];
		return 1'b1;
	endfunction

	task automatic send_item(input logic act, input logic [JNT_W-1:0] j,
		input logic signed [ANG_W-1:0] q, input logic signed [ANG_W-1:0] qr);
		torque_cmd_t cmd;
		if (!full_rate) begin
			while ($urandom_range(0, 99) < 33) begin
				item_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_if.valid <= 1'b1;
		item_if.action <= act;
		item_if.joint <= j;
		item_if.angle <= q;
		item_if.angle_ref <= qr;
		do @(posedge clk); while (!item_if.ready);
		items_sent++;
		if (act == ACT_SEED) begin
			seeds_sent++;
		end
		if (advance_joint(act, j, q, qr, cmd)) begin
			torque_q.push_back(cmd);
		end
	endtask

	function automatic logic signed [ANG_W-1:0] random_offset();
		return $signed($urandom) >>> $urandom_range(4, 31);
	endfunction

	// Mostly well-formed trajectories: each joint is seeded first and then stepped with
	// nearby angles and references, with some fully random transactions mixed in.
	task automatic send_random_item();
		logic [JNT_W-1:0]        j;
		logic signed [ANG_W-1:0] q;
		logic signed [ANG_W-1:0] qr;
		longint                  vel;
		j = JNT_W'($urandom_range(0, NUM_JOINTS - 1));
		if (!seeded[j] || $urandom_range(0, 19) == 0) begin
			q = ($urandom_range(0, 3) == 0) ? $urandom : random_offset();
			qr = $urandom;
			send_item(ACT_SEED, j, q, qr);
		end else if ($urandom_range(0, 9) == 0) begin
			send_item(ACT_STEP, j, $urandom, $urandom);
		end else begin
			q = hist_angle[j] + random_offset();
			if (j >= 30) begin
				vel = (longint'(q) - longint'(hist_angle[j])) * model_rate;
				vel = vel + longint'(random_offset());
				qr = vel[ANG_W-1:0];
			end else begin
				qr = ($urandom_range(0, 3) == 0) ? q : q + random_offset();
			end
			send_item(ACT_STEP, j, q, qr);
		end
	endtask

	task automatic send_random_items(input int count);
		repeat (count) send_random_item();
	endtask

	task automatic drain_results();
		item_if.valid <= 1'b0;
		do @(posedge clk); while (torque_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_rate(input logic [RATE_W-1:0] r);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_rate = r;
		rate_writes++;
	endtask

	task automatic test_directed();
		send_item(ACT_SEED, 5'd0, 32'sd0, 32'sd0);
		send_item(ACT_STEP, 5'd0, 32'sd0, 32'sd0);
		send_item(ACT_STEP, 5'd0, 32'sd100, 32'sd0);
		send_item(ACT_STEP, 5'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(ACT_STEP, 5'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(ACT_SEED, 5'd3, -32'sd1000, 32'sd77);
		send_item(ACT_STEP, 5'd3, -32'sd990, -32'sd1000);
		send_item(ACT_SEED, 5'd21, 32'sh7FFF_FFFF, 32'sd0);
		send_item(ACT_STEP, 5'd21, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_item(ACT_SEED, 5'd25, 32'sd0, 32'sd0);
		send_item(ACT_STEP, 5'd25, 32'sd1049, 32'sd0);
		send_item(ACT_STEP, 5'd25, 32'sd2098, 32'sd5);
		send_item(ACT_STEP, 5'd25, 32'sd0, 32'sd12345);
		send_item(ACT_SEED, 5'd26, 32'sd5000, 32'sd0);
		send_item(ACT_STEP, 5'd26, 32'sd5010, 32'sd5000);
		send_item(ACT_SEED, 5'd30, 32'sd0, 32'sd0);
		send_item(ACT_STEP, 5'd30, 32'sd10, 32'sd10000);
		send_item(ACT_STEP, 5'd30, 32'sd20, 32'sh7FFF_FFFF);
		send_item(ACT_STEP, 5'd30, 32'sd20, 32'sh8000_0000);
		send_item(ACT_SEED, 5'd31, 32'sh8000_0000, 32'sd0);
		send_item(ACT_STEP, 5'd31, 32'sh7FFF_FFFF, 32'sd0);
		send_item(ACT_SEED, 5'd20, 32'sd1, 32'sd0);
		send_item(ACT_STEP, 5'd20, -32'sd1, 32'sd1);
	endtask

	task automatic test_rate_extremes();
		set_rate(16'd0);
		send_random_items(60);
		set_rate(16'd1);
		send_random_items(60);
		set_rate(16'hFFFF);
		send_random_items(60);
		set_rate(16'd1000);
	endtask

	task automatic test_output_stall();
		full_rate = 1'b1;
		stall_request = 400;
		send_random_items(20);
		full_rate = 1'b0;
	endtask

	task automatic test_sender_pause();
		repeat (3) begin
			send_random_items(30);
			drain_results();
		end
	endtask

	task automatic test_full_rate();
		full_rate = 1'b1;
		send_random_items(200);
		full_rate = 1'b0;
	endtask

	task automatic test_random_rates();
		repeat (6) begin
			if ($urandom_range(0, 3) == 0) begin
				set_rate(RATE_W'($urandom_range(1, 65535)));
			end else begin
				set_rate(RATE_W'($urandom_range(50, 3000)));
			end
			send_random_items(240);
		end
	endtask

	task automatic check_torque_cmd(input torque_cmd_t got);
		torque_cmd_t exp_cmd;
		results_checked++;
		if (torque_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result: joint %0d torque %0d clamped %0d",
					got.joint, got.torque, got.clamped);
			end
			return;
		end
		exp_cmd = torque_q.pop_front();
		if (got !== exp_cmd) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: joint %0d torque %0d clamped %0d, expected %0d %0d %0d",
					got.joint, got.torque, got.clamped,
					exp_cmd.joint, exp_cmd.torque, exp_cmd.clamped);
			end
		end
	endtask

	initial begin
		torque_cmd_t got;
		int          stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
				got.joint = result_if.joint_out;
				got.torque = result_if.torque;
				got.clamped = result_if.clamped;
				check_torque_cmd(got);
			end
			if (stall_request != 0) begin
				stall_left = stall_request;
				stall_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (full_rate) begin
				result_if.ready <= 1'b1;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= 33);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_if.valid = 1'b0;
		item_if.action = ACT_SEED;
		item_if.joint = '0;
		item_if.angle = '0;
		item_if.angle_ref = '0;
		model_rate = RATE_RST;
		for (int i = 0; i < NUM_JOINTS; i++) begin
			seeded[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_rate_extremes();
		test_output_stall();
		test_sender_pause();
		test_full_rate();
		test_random_rates();
		drain_results();
		repeat (40) @(posedge clk);
		if (torque_q.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", torque_q.size());
		end
		$display("Sent %0d transactions, %0d of them seeds, under %0d rate settings.",
			items_sent, seeds_sent, rate_writes + 1);
		$display("Checked %0d torque results with %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
